/* rtl/core/ih_pkg.sv */
// shared constants for the integer hypotenuse core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ih_pkg;
    localparam int COORD_W      = 16;              // input coordinate width
    localparam int MAG_W        = COORD_W + 1;     // magnitude of -32768 needs one more bit
    localparam int SQ_W         = 2 * COORD_W - 1; // one square is at most 2^30
    localparam int DD_W         = 2 * COORD_W;     // sum of squares is at most 2^31
    localparam int ROOT_W       = 16;              // estimate width
    localparam int QUO_W        = ROOT_W + 1;      // quotient bits per newton step
    localparam int REFINE_STEPS = 3;               // default newton step count
endpackage
`default_nettype wire

/* rtl/core/ih_if.sv */
// stream interfaces for coordinate pairs and distances
// depends on ih_pkg
`timescale 1ns / 1ps
`default_nettype none
interface ih_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [ih_pkg::COORD_W-1:0]   delta_x;
    logic signed [ih_pkg::COORD_W-1:0]   delta_y;
    modport source (output valid, output delta_x, output delta_y, input ready);
    modport sink   (input valid, input delta_x, input delta_y, output ready);
endinterface

interface ih_out_if;
    logic                          valid;
    logic                          ready;
    logic [ih_pkg::ROOT_W-1:0]     distance;
    modport source (output valid, output distance, input ready);
    modport sink   (input valid, input distance, output ready);
endinterface
`default_nettype wire

/* rtl/core/integer_hypotenuse.sv */
// integer hypotenuse: newton-refined sqrt(dx*dx + dy*dy)
// depends on ih_pkg, ih_if, ih_newton_step
//
// channel   dir  fields                 beat
// i_in      in   delta_x, delta_y s16   one coordinate pair
// o_out     out  distance u16           one distance per input beat
//
// one beat per cycle while the output register is not stalled; the pipe holds
// magnitude, square/guess and sum stages, then 17 restoring-divide stages
// plus one averaging stage per newton step
// synchronous active-low reset clears only the valid bits
// the whole pipe advances together whenever the output register is empty
// or taken, so a stall holds every stage in place
`timescale 1ns / 1ps
`default_nettype none
module integer_hypotenuse #(
    parameter int REFINE_STEPS = ih_pkg::REFINE_STEPS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ih_in_if.sink     i_in,
    ih_out_if.source  o_out
);
    localparam int CW = ih_pkg::COORD_W;
    localparam int MW = ih_pkg::MAG_W;
    localparam int SW = ih_pkg::SQ_W;
    localparam int DW = ih_pkg::DD_W;
    localparam int RW = ih_pkg::ROOT_W;

    logic w_en;

    // global advance: output slot free or being drained
    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    // stage 1: absolute values
    logic          r_v1;
    logic [MW-1:0] r_ax;
    logic [MW-1:0] r_ay;
    logic [MW-1:0] w_sx;
    logic [MW-1:0] w_sy;

    assign w_sx = MW'(i_in.delta_x);
    assign w_sy = MW'(i_in.delta_y);

    // stage 2: squares and starting guess max + min/2
    logic          r_v2;
    logic [SW-1:0] r_sqx;
    logic [SW-1:0] r_sqy;
    logic [RW-1:0] r_guess;
    logic [MW-1:0] w_big;
    logic [MW-1:0] w_small;
    logic [MW-1:0] w_guess;
    logic [2*MW-1:0] w_px;
    logic [2*MW-1:0] w_py;

    assign w_big   = (r_ax > r_ay) ? r_ax : r_ay;
    assign w_small = (r_ax > r_ay) ? r_ay : r_ax;
    assign w_guess = w_big + (w_small >> 1);
    assign w_px    = r_ax * r_ax;
    assign w_py    = r_ay * r_ay;

    // stage 3: sum of squares, zero flag for the all-zero input
    logic          r_v3;
    logic [DW-1:0] r_dd;
    logic [RW-1:0] r_root;
    logic          r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ax    <= i_in.delta_x[CW-1] ? (-w_sx) : w_sx;
            r_ay    <= i_in.delta_y[CW-1] ? (-w_sy) : w_sy;
            r_sqx   <= w_px[SW-1:0];
            r_sqy   <= w_py[SW-1:0];
            r_guess <= w_guess[RW-1:0];
            r_dd    <= DW'(r_sqx) + DW'(r_sqy);
            r_root  <= r_guess;
            r_zero  <= (r_guess == '0);
        end
    end

    // newton step chain
    logic          w_v    [0:REFINE_STEPS];
    logic [DW-1:0] w_dd   [0:REFINE_STEPS];
    logic [RW-1:0] w_root [0:REFINE_STEPS];
    logic          w_zero [0:REFINE_STEPS];

    assign w_v[0]    = r_v3;
    assign w_dd[0]   = r_dd;
    assign w_root[0] = r_root;
    assign w_zero[0] = r_zero;

    for (genvar s = 0; s < REFINE_STEPS; s++) begin : g_step
        ih_newton_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[s]),
            .i_dd    (w_dd[s]),
            .i_root  (w_root[s]),
            .i_zero  (w_zero[s]),
            .o_valid (w_v[s+1]),
            .o_dd    (w_dd[s+1]),
            .o_root  (w_root[s+1]),
            .o_zero  (w_zero[s+1])
        );
    end

    // last step register is the output register
    assign o_out.valid    = w_v[REFINE_STEPS];
    assign o_out.distance = w_zero[REFINE_STEPS] ? '0 : w_root[REFINE_STEPS];
endmodule
`default_nettype wire

/* rtl/core/ih_newton_step.sv */
// one pipelined newton step r = (dd / r + r) >> 1, one quotient bit per stage
// depends on ih_pkg
`timescale 1ns / 1ps
`default_nettype none
module ih_newton_step (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [ih_pkg::DD_W-1:0]     i_dd,
    input  wire logic [ih_pkg::ROOT_W-1:0]   i_root,
    input  wire logic                        i_zero,
    output logic                             o_valid,
    output logic [ih_pkg::DD_W-1:0]          o_dd,
    output logic [ih_pkg::ROOT_W-1:0]        o_root,
    output logic                             o_zero
);
    localparam int NQ = ih_pkg::QUO_W;
    localparam int RW = ih_pkg::ROOT_W;
    localparam int DW = ih_pkg::DD_W;

    logic          w_valid [0:NQ];
    logic [DW-1:0] w_dd    [0:NQ];
    logic [RW-1:0] w_root  [0:NQ];
    logic          w_zero  [0:NQ];
    logic [RW-1:0] w_rem   [0:NQ];
    logic [NQ-1:0] w_quo   [0:NQ];

    // dd < root * 2^NQ, so the top bits already sit below the divisor
    assign w_valid[0] = i_valid;
    assign w_dd[0]    = i_dd;
    assign w_root[0]  = i_root;
    assign w_zero[0]  = i_zero;
    assign w_rem[0]   = RW'(i_dd[DW-1:NQ]);
    assign w_quo[0]   = '0;

    for (genvar g = 0; g < NQ; g++) begin : g_div
        logic          r_valid;
        logic [DW-1:0] r_dd;
        logic [RW-1:0] r_root;
        logic          r_zero;
        logic [RW-1:0] r_rem;
        logic [NQ-1:0] r_quo;
        logic [RW:0]   w_trial;
        logic [RW:0]   w_diff;
        logic          w_ge;

        assign w_trial = {w_rem[g], w_dd[g][NQ-1-g]};
        assign w_diff  = w_trial - {1'b0, w_root[g]};
        assign w_ge    = w_trial >= {1'b0, w_root[g]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (i_en) begin
                r_valid <= w_valid[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dd   <= w_dd[g];
                r_root <= w_root[g];
                r_zero <= w_zero[g];
                r_rem  <= w_ge ? w_diff[RW-1:0] : w_trial[RW-1:0];
                r_quo  <= {w_quo[g][NQ-2:0], w_ge};
            end
        end

        assign w_valid[g+1] = r_valid;
        assign w_dd[g+1]    = r_dd;
        assign w_root[g+1]  = r_root;
        assign w_zero[g+1]  = r_zero;
        assign w_rem[g+1]   = r_rem;
        assign w_quo[g+1]   = r_quo;
    end

    // average of quotient and old estimate
    logic [NQ:0] w_sum;
    assign w_sum = {1'b0, w_quo[NQ]} + (NQ+1)'(w_root[NQ]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= w_valid[NQ];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_dd   <= w_dd[NQ];
            o_zero <= w_zero[NQ];
            o_root <= w_zero[NQ] ? '0 : w_sum[RW:1];
        end
    end
endmodule
`default_nettype wire
